// ----- rtl/gpu_scalar_alu_macros.svh -----
// Assertion macros for the scalar ALU checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef GPU_SCALAR_ALU_MACROS_SVH
`define GPU_SCALAR_ALU_MACROS_SVH

// same-cycle implication
`define GSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gsa_pkg;

    localparam int unsigned OpWidth   = 5;
    localparam int unsigned DataWidth = 64;
    localparam int unsigned HalfWidth = 32;
    localparam int unsigned ImmWidth  = 16;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD         = 5'd0,
        OP_ADDK        = 5'd1,
        OP_MUL         = 5'd2,
        OP_MOV32       = 5'd3,
        OP_MOV64       = 5'd4,
        OP_MOVK        = 5'd5,
        OP_AND32       = 5'd6,
        OP_OR32        = 5'd7,
        OP_AND64       = 5'd8,
        OP_OR64        = 5'd9,
        OP_NOT64       = 5'd10,
        OP_NOR64       = 5'd11,
        OP_ANDN2_64    = 5'd12,
        OP_ORN2_64     = 5'd13,
        OP_SHL32       = 5'd14,
        OP_SHR32       = 5'd15,
        OP_BFE32       = 5'd16,
        OP_CMP_EQ32    = 5'd17,
        OP_CMP_NE32    = 5'd18,
        OP_SELECT32    = 5'd19,
        OP_SELECT64    = 5'd20,
        OP_SAVEEXEC64  = 5'd21,
        OP_WQM32       = 5'd22,
        OP_WQM64       = 5'd23
    } op_t;

    typedef struct packed {
        logic                 flag;
        logic [DataWidth-1:0] mask;
    } gsa_state_t;

    typedef struct packed {
        logic [DataWidth-1:0] result_value;
        logic                 writes_destination;
        gsa_state_t           next_state;
    } gsa_exec_t;

endpackage

`default_nettype wire

// ----- rtl/gsa_exec.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsa_exec (
    input  wire logic [gsa_pkg::OpWidth-1:0]   operation,
    input  wire logic [gsa_pkg::DataWidth-1:0] source_a,
    input  wire logic [gsa_pkg::DataWidth-1:0] source_b,
    input  wire logic signed [gsa_pkg::ImmWidth-1:0] immediate,
    input  wire gsa_pkg::gsa_state_t           state,
    output gsa_pkg::gsa_exec_t                 exec
);
    import gsa_pkg::*;

    localparam int unsigned NibbleCount = DataWidth / 4;

    function automatic logic [DataWidth-1:0] whole_quad(input logic [DataWidth-1:0] v);
        logic [DataWidth-1:0] r;
        r = '0;
        for (int q = 0; q < NibbleCount; q++)
        begin
            r[q*4 +: 4] = {4{|v[q*4 +: 4]}};
        end
        return r;
    endfunction

    logic [HalfWidth-1:0] a32;
    logic [HalfWidth-1:0] b32;
    logic [HalfWidth-1:0] imm32;
    logic [HalfWidth-1:0] mul_lo;
    logic [4:0]           shamt;
    logic [6:0]           field_width;
    logic [HalfWidth-1:0] field_mask;
    logic [DataWidth-1:0] res;
    logic                 wr;
    logic                 set_flag;
    logic                 flag_next;
    logic [DataWidth-1:0] mask_next;

    assign a32         = source_a[HalfWidth-1:0];
    assign b32         = source_b[HalfWidth-1:0];
    assign imm32       = {{(HalfWidth-ImmWidth){immediate[ImmWidth-1]}}, immediate};
    assign mul_lo      = a32 * b32;
    assign shamt       = source_b[4:0];
    assign field_width = source_b[22:16];
    assign field_mask  = (field_width >= 7'd32) ? '1
                         : ((HalfWidth'(1) << field_width[4:0]) - HalfWidth'(1));

    always_comb
    begin
        res       = '0;
        wr        = 1'b1;
        set_flag  = 1'b0;
        flag_next = state.flag;
        mask_next = state.mask;
        case (operation)
            OP_ADD:        res = {32'b0, a32 + b32};
            OP_ADDK:       res = {32'b0, a32 + imm32};
            OP_MUL:        res = {32'b0, mul_lo};
            OP_MOV32:      res = {32'b0, a32};
            OP_MOV64:      res = source_a;
            OP_MOVK:       res = {32'b0, imm32};
            OP_AND32:
            begin
                res      = {32'b0, a32 & b32};
                set_flag = 1'b1;
            end
            OP_OR32:
            begin
                res      = {32'b0, a32 | b32};
                set_flag = 1'b1;
            end
            OP_AND64:
            begin
                res      = source_a & source_b;
                set_flag = 1'b1;
            end
            OP_OR64:
            begin
                res      = source_a | source_b;
                set_flag = 1'b1;
            end
            OP_NOT64:
            begin
                res      = ~source_a;
                set_flag = 1'b1;
            end
            OP_NOR64:
            begin
                res      = ~(source_a | source_b);
                set_flag = 1'b1;
            end
            OP_ANDN2_64:
            begin
                res      = source_a & ~source_b;
                set_flag = 1'b1;
            end
            OP_ORN2_64:
            begin
                res      = source_a | ~source_b;
                set_flag = 1'b1;
            end
            OP_SHL32:
            begin
                res      = {32'b0, a32 << shamt};
                set_flag = 1'b1;
            end
            OP_SHR32:
            begin
                res      = {32'b0, a32 >> shamt};
                set_flag = 1'b1;
            end
            OP_BFE32:
            begin
                res      = {32'b0, (a32 >> shamt) & field_mask};
                set_flag = 1'b1;
            end
            OP_CMP_EQ32:
            begin
                wr        = 1'b0;
                flag_next = (a32 == b32);
            end
            OP_CMP_NE32:
            begin
                wr        = 1'b0;
                flag_next = (a32 != b32);
            end
            OP_SELECT32:   res = {32'b0, state.flag ? a32 : b32};
            OP_SELECT64:   res = state.flag ? source_a : source_b;
            OP_SAVEEXEC64:
            begin
                res       = state.mask;
                mask_next = source_a & state.mask;
            end
            OP_WQM32:      res = whole_quad({32'b0, a32});
            OP_WQM64:      res = whole_quad(source_a);
            default:       wr = 1'b0;
        endcase
        if (set_flag)
        begin
            flag_next = |res;
        end
    end

    assign exec.result_value       = res;
    assign exec.writes_destination = wr;
    assign exec.next_state.flag    = flag_next;
    assign exec.next_state.mask    = mask_next;

endmodule

`default_nettype wire

// ----- rtl/gpu_scalar_alu.sv -----
// A beat passes the input register, then execute logic and one 32x32 multiply in one stage,
// then the result register. Throughput: one instruction per cycle unless the output stalls.
// The condition flag and exec mask update as each result is registered, so the next
// instruction sees them with no bubble.
// Reset: asynchronous, active low; flag clears, exec mask sets to all ones, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module gpu_scalar_alu (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output      logic                               in_stall,
    input  wire logic [gsa_pkg::OpWidth-1:0]        operation,
    input  wire logic [gsa_pkg::DataWidth-1:0]      source_a,
    input  wire logic [gsa_pkg::DataWidth-1:0]      source_b,
    input  wire logic signed [gsa_pkg::ImmWidth-1:0] immediate,
    output      logic                               out_valid,
    input  wire logic                               out_stall,
    output      logic [gsa_pkg::DataWidth-1:0]      result_value,
    output      logic                               writes_destination,
    output      logic                               condition_flag,
    output      logic [gsa_pkg::DataWidth-1:0]      execute_mask
);
    import gsa_pkg::*;

    logic                        in_valid_reg;
    logic [OpWidth-1:0]          operation_reg;
    logic [DataWidth-1:0]        source_a_reg;
    logic [DataWidth-1:0]        source_b_reg;
    logic signed [ImmWidth-1:0]  immediate_reg;

    logic                        out_valid_reg;
    logic [DataWidth-1:0]        result_value_reg;
    logic                        writes_destination_reg;
    logic                        condition_flag_reg;
    logic [DataWidth-1:0]        execute_mask_reg;

    gsa_state_t state_reg;
    gsa_state_t state_next;
    gsa_exec_t  exec;

    logic out_load;
    logic in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_load  = in_valid && !in_stall;

    gsa_exec u_exec (
        .operation (operation_reg),
        .source_a  (source_a_reg),
        .source_b  (source_b_reg),
        .immediate (immediate_reg),
        .state     (state_reg),
        .exec      (exec)
    );

    assign state_next = out_load ? exec.next_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg.flag <= 1'b0;
            state_reg.mask <= '1;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            operation_reg <= operation;
            source_a_reg  <= source_a;
            source_b_reg  <= source_b;
            immediate_reg <= immediate;
        end
        if (out_load)
        begin
            result_value_reg       <= exec.result_value;
            writes_destination_reg <= exec.writes_destination;
            condition_flag_reg     <= exec.next_state.flag;
            execute_mask_reg       <= exec.next_state.mask;
        end
    end

    assign out_valid          = out_valid_reg;
    assign result_value       = result_value_reg;
    assign writes_destination = writes_destination_reg;
    assign condition_flag     = condition_flag_reg;
    assign execute_mask       = execute_mask_reg;

endmodule

`default_nettype wire

// ----- rtl/gsa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "gpu_scalar_alu_macros.svh"

module gsa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [gsa_pkg::DataWidth-1:0] result_value,
    input wire logic                          writes_destination,
    input wire logic [gsa_pkg::DataWidth-1:0] execute_mask
);

    // hold a stalled result beat
    `GSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_value) && $stable(writes_destination), "stalled result beat changed")

    // input side only stalls when the result side is stalled
    `GSA_ASSERT_NOW(a_stall_path, !out_stall, !in_stall, "input stalled with output free")

    // compares and no-ops return a zero value
    `GSA_ASSERT_NOW(a_nowrite_zero, out_valid && !writes_destination, result_value == '0, "non-writing result is nonzero")

    // exec mask only drops lanes
    `GSA_ASSERT_NOW(a_mask_shrinks, out_valid && $past(out_valid), (execute_mask & ~$past(execute_mask)) == '0, "exec mask gained lanes")

endmodule

bind gpu_scalar_alu gsa_checker u_gsa_checker (.*);

`default_nettype wire
